// ----- design/qdc_pkg.sv -----
// Shared types and constants for the dual quadrature counter.
// No dependencies; imported by qdc_enc and dual_quadrature_counter.
`default_nettype none

package qdc_pkg;

    // Stream payload widths.
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 160;
    localparam int PIN_W       = 4;
    localparam int COUNT_OUT_W = 32;
    localparam int DELTA_OUT_W = 16;

    // Levels of one encoder's two channels.
    typedef struct packed {
        logic b;
        logic a;
    } qdc_pins_t;

    // Reported values of one encoder; the forward count sits in the lowest bits.
    typedef struct packed {
        logic [DELTA_OUT_W-1:0] delta;
        logic [COUNT_OUT_W-1:0] back;
        logic [COUNT_OUT_W-1:0] fwd;
    } qdc_enc_out_t;

endpackage

`default_nettype wire

// ----- design/dual_quadrature_counter.sv -----
// Top level of the dual quadrature counter: input register, two encoder
// decoders and the result register. Depends on qdc_pkg and qdc_enc.
// An input transfer passes through the input register, then the result register, to m_tdata.
// Throughput: one sample per cycle; the input register takes one more
// sample while a result waits, then s_tready drops until m_tready returns.
// Reset (aresetn low, synchronous) clears counts, deltas, the previous pin
// sample and both valid flags.
`default_nettype none

module dual_quadrature_counter #(
    parameter int COUNT_BITS = 32,
    parameter int DELTA_BITS = 16
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // Bit 0 pin_a0, bit 1 pin_b0, bit 2 pin_a1, bit 3 pin_b1, bits 7:4 ignored.
    input  wire  [qdc_pkg::S_TDATA_W-1:0]   s_tdata,
    // Tick: clears both deltas after this sample's result.
    input  wire                             s_tlast,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // From bit 0 up: fwd_count_0, back_count_0, delta_0,
    // fwd_count_1, back_count_1, delta_1.
    output logic [qdc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import qdc_pkg::*;

    logic             in_valid_reg;
    logic [PIN_W-1:0] in_pins_reg;
    logic             in_tick_reg;
    logic             m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic         advance;
    logic         upd;
    qdc_pins_t    pins0;
    qdc_pins_t    pins1;
    qdc_enc_out_t res0;
    qdc_enc_out_t res1;

    assign advance  = !m_valid_reg || m_tready;
    assign upd      = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign pins0.a = in_pins_reg[0];
    assign pins0.b = in_pins_reg[1];
    assign pins1.a = in_pins_reg[2];
    assign pins1.b = in_pins_reg[3];

    qdc_enc #(
        .COUNT_BITS (COUNT_BITS),
        .DELTA_BITS (DELTA_BITS)
    ) u_enc0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .pins    (pins0),
        .tick    (in_tick_reg),
        .result  (res0)
    );

    qdc_enc #(
        .COUNT_BITS (COUNT_BITS),
        .DELTA_BITS (DELTA_BITS)
    ) u_enc1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .pins    (pins1),
        .tick    (in_tick_reg),
        .result  (res1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pins_reg <= s_tdata[PIN_W-1:0];
            in_tick_reg <= s_tlast;
        end
        if (upd) begin
            m_data_reg <= {res1, res0};
        end
    end

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_tready)
        else $error("input taken while both stages are full");

    a_update_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        upd |=> m_valid_reg)
        else $error("processed sample produced no result");

    a_transfer_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted sample not held in the input register");

endmodule

`default_nettype wire

// ----- design/qdc_enc.sv -----
// Step decoder and counters for one quadrature encoder.
// Depends on qdc_pkg for the pin and result types.
`default_nettype none

module qdc_enc #(
    parameter int COUNT_BITS = 32,
    parameter int DELTA_BITS = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   upd,
    input  wire qdc_pkg::qdc_pins_t pins,
    input  wire                   tick,
    output qdc_pkg::qdc_enc_out_t result
);
    import qdc_pkg::*;

    qdc_pins_t             last_reg;
    logic [COUNT_BITS-1:0] fwd_reg;
    logic [COUNT_BITS-1:0] back_reg;
    logic [DELTA_BITS-1:0] delta_reg;

    logic [COUNT_BITS-1:0] fwd_next;
    logic [COUNT_BITS-1:0] back_next;
    logic [DELTA_BITS-1:0] delta_next;
    logic                  chg_a;
    logic                  chg_b;
    logic                  step_fwd;
    logic                  step_back;

    // A change of A is forward when A != B; a change of B is forward when
    // A == B. When both change, exactly one forward and one backward step
    // result, so each count moves by at most one per sample.
    always_comb begin
        chg_a     = pins.a ^ last_reg.a;
        chg_b     = pins.b ^ last_reg.b;
        step_fwd  = (chg_a && (pins.a != pins.b)) || (chg_b && (pins.a == pins.b));
        step_back = (chg_a && (pins.a == pins.b)) || (chg_b && (pins.a != pins.b));
        fwd_next  = fwd_reg + COUNT_BITS'(step_fwd);
        back_next = back_reg + COUNT_BITS'(step_back);
        delta_next = delta_reg + DELTA_BITS'(step_fwd) - DELTA_BITS'(step_back);
    end

    always_comb begin
        result.fwd   = COUNT_OUT_W'(fwd_next);
        result.back  = COUNT_OUT_W'(back_next);
        result.delta = DELTA_OUT_W'(delta_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            fwd_reg   <= '0;
            back_reg  <= '0;
            delta_reg <= '0;
        end else if (upd) begin
            last_reg  <= pins;
            fwd_reg   <= fwd_next;
            back_reg  <= back_next;
            // The delta is reported first and cleared afterwards on a tick.
            delta_reg <= tick ? '0 : delta_next;
        end
    end

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !upd |=> $stable(fwd_reg) && $stable(back_reg) && $stable(last_reg))
        else $error("encoder state moved without an update");

    a_no_change_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && (pins == last_reg)) |=> $stable(fwd_reg) && $stable(back_reg))
        else $error("counts moved on an unchanged sample");

    a_tick_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && tick) |=> (delta_reg == '0))
        else $error("delta not cleared after a tick");

endmodule

`default_nettype wire
